[src/sorted_priority_queue_macros.svh]
// Assertion macros for the sorted priority queue.
// Uses the names clk and arst_n of the module that includes this file.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTH
`define SPQ_ASSERT(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define SPQ_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SPQ_ASSERT(name, cond)
`define SPQ_ASSERT_IMP(name, ante, cons)
`endif
`endif

[src/spq_pkg.sv]
// Shared constants and types of the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing.
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W = 32;
	localparam int TAG_W = 32;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic del;
		entry_t item;
	} cell_ctrl_t;

endpackage

[src/spq_cell.sv]
// One slot of the sorted row: holds an entry and shifts toward its neighbors.
// Depends on spq_pkg.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               held,
	input  logic               prev_le,
	input  spq_pkg::entry_t    prev_entry,
	input  spq_pkg::entry_t    next_entry,
	output logic               le,
	output spq_pkg::entry_t    entry
);
	import spq_pkg::*;

	entry_t entry_q;

	assign le = held & ($signed(entry_q.key) <= $signed(ctrl.item.key));
	assign entry = entry_q;

	// An insert keeps entries with keys not above the new key, places the new
	// entry in the first slot past them and moves the rest up by one.
	always_ff @(posedge clk) begin
		if (ctrl.ins && !le) begin
			entry_q <= prev_le ? ctrl.item : prev_entry;
		end else if (ctrl.del) begin
			entry_q <= next_entry;
		end
	end

endmodule

[src/sorted_priority_queue.sv]
// Top level of the sorted priority queue: a row of spq_cell slots and the
// result register. Depends on spq_pkg, spq_cell and the assertion macros.
//
// Use: each word on the s channel is one operation. s_tuser is the operation
// (insert or delete the smallest key), s_tdata carries key and tag of an
// insert. Each operation gives exactly one word on the m channel with its
// status in m_tuser and the removed key, tag and occupancy in m_tdata.
// Entries with equal keys leave in arrival order.
// The result is registered and is valid in the cycle after acceptance.
// Throughput is one operation per cycle while the result is taken; all slots
// compare against the new key and shift in the same cycle, so the row sets that rate.
// When the receiver stalls, the result waits in the output register and
// s_tready drops until it is taken, so no result is lost.
// Reset empties the queue at once and clears the pending result; no
// clearing pass is needed since only held slots are ever read.
// An insert into a full queue and a delete from an empty one change nothing
// and are reported by status.
`include "sorted_priority_queue_macros.svh"
module sorted_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] new_key, [63:32] data_tag
	input  logic [0:0]  s_tuser,  // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // [31:0] out_key, [63:32] out_tag, [68:64] occupancy
	output logic [1:0]  m_tuser   // [1:0] status
);
	import spq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic out_valid_q;
	status_t status_q;
	entry_t out_entry_q;
	logic [CNT_W-1:0] occ_q;

	logic accept, is_insert, full, empty, ins_ok, del_ok;
	cell_ctrl_t ctrl;
	logic [CAPACITY-1:0] le_w;
	logic [CAPACITY-1:0] held_w;
	entry_t ent_w [CAPACITY];

	assign s_tready = !out_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;
	assign is_insert = (s_tuser[0] == OP_INSERT);
	assign full = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign ins_ok = accept && is_insert && !full;
	assign del_ok = accept && !is_insert && !empty;

	assign ctrl.ins = ins_ok;
	assign ctrl.del = del_ok;
	assign ctrl.item.key = s_tdata[KEY_W-1:0];
	assign ctrl.item.tag = s_tdata[KEY_W+TAG_W-1:KEY_W];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic prev_le;
		entry_t prev_entry, next_entry;
		assign held_w[i] = CNT_W'(i) < count_q;
		if (i == 0) begin : g_first
			assign prev_le = 1'b1;
			assign prev_entry = '0;
		end else begin : g_mid
			assign prev_le = le_w[i-1];
			assign prev_entry = ent_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_entry = '0;
		end else begin : g_inner
			assign next_entry = ent_w[i+1];
		end
		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.held       (held_w[i]),
			.prev_le    (prev_le),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.le         (le_w[i]),
			.entry      (ent_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ins_ok) begin
				count_q <= count_q + 1'b1;
			end else if (del_ok) begin
				count_q <= count_q - 1'b1;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_insert) begin
				status_q <= full ? ST_FULL : ST_OK;
			end else begin
				status_q <= empty ? ST_EMPTY : ST_OK;
			end
			out_entry_q <= del_ok ? ent_w[0] : '0;
			if (ins_ok) begin
				occ_q <= count_q + 1'b1;
			end else if (del_ok) begin
				occ_q <= count_q - 1'b1;
			end else begin
				occ_q <= count_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = status_q;
	assign m_tdata = {3'b000, occ_q, out_entry_q.tag, out_entry_q.key};

	`SPQ_ASSERT(a_count_range, count_q <= CNT_W'(CAPACITY))
	`SPQ_ASSERT_IMP(a_result_follows, accept, m_tvalid)
	`SPQ_ASSERT_IMP(a_insert_grows, ins_ok, count_q == $past(count_q) + 1'b1)
	`SPQ_ASSERT_IMP(a_empty_flag, accept && !is_insert && empty, m_tuser == ST_EMPTY)

endmodule
